@@ hdl/dcc_pkg.sv @@
// Shared types and constants for the direction cone classifier.
// No dependencies; every other file imports this package.
package dcc_pkg;

   // Widths of the direction components and of the range count register.
   localparam int DIR_W         = 16;
   localparam int RANGE_COUNT_W = 2;

   // Width of the operands that enter a CORDIC pipe (sqrt result reaches 2^15).
   localparam int CORDIC_IN_W   = DIR_W + 1;
   localparam int CORDIC_SHIFT  = 14;
   localparam int CORDIC_XW     = CORDIC_IN_W + CORDIC_SHIFT + 3;
   localparam int CORDIC_STEPS  = 30;
   localparam int ACC_W         = 32;

   // Square root of 2^30 - z^2: one result bit per stage.
   localparam int SQRT_STEPS    = 16;
   localparam int SQRT_W        = 32;
   localparam logic [SQRT_W-1:0] UNIT_SQ = 32'h4000_0000;

   // Configuration register indexes that do not depend on the range count.
   localparam int CSR_RANGE_COUNT = 0;
   localparam int CSR_RANGE_BASE  = 1;

   // Arctangent of 2^-i, full circle equals 2^32.
   localparam logic [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   // Data that rides alongside the square root pipe.
   typedef struct packed {
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
      logic                    xy_zero;
      logic                    final_point;
   } dcc_side_type;

endpackage

@@ hdl/dcc_if.sv @@
// Handshake interfaces for the request and response channels.
// Depends on dcc_pkg for the field widths.
interface dcc_req_if;
   import dcc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;
   logic signed [DIR_W-1:0] dir_z;
   logic                    final_point;

   modport source (output valid, dir_x, dir_y, dir_z, final_point, input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, final_point, output ready);
endinterface

interface dcc_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic final_point_out;

   modport source (output valid, inside_res, final_point_out, input ready);
   modport sink   (input valid, inside_res, final_point_out, output ready);
endinterface

@@ hdl/direction_cone_classifier_top.sv @@
// Top level of the direction cone classifier: square root, two CORDIC pipes
// and the range check. Depends on dcc_pkg, dcc_if and the three submodules.
//
// Usage:
// - req_chan carries one direction (dir_x, dir_y, dir_z in Q1.15, final_point)
//   per transfer; rsp_chan returns inside_res and final_point_out per item,
//   in order, one result for each request.
// - The csr port writes one register per cycle in which csr_we is high:
//   index 0 range count, then start and end of each azimuth range, then the
//   polar low and high bounds. Write only while no item is in flight.
// - A request passes through 18 stages of square root, 32 stages of CORDIC
//   (set by the 30 rotation steps) and the response register before the
//   response is valid.
// - Throughput is one item per cycle while the receiver takes each response.
// - When the receiver stalls, the whole pipe holds and req_chan.ready drops
//   until the waiting response is taken; nothing is lost or repeated.
// - Synchronous reset empties the pipe and loads the register defaults
//   (no active range, full azimuth ranges, polar band 0 to pi).
module direction_cone_classifier_top #(
   parameter int NUM_RANGES = 2,
   parameter int ANGLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   dcc_req_if.sink                                req_chan,
   dcc_rsp_if.source                              rsp_chan,
   input  logic                                   csr_we,
   input  logic [$clog2(2*NUM_RANGES+3)-1:0]      csr_index,
   input  logic [ANGLE_BITS-1:0]                  csr_wdata
);
   import dcc_pkg::*;

   localparam int CSR_IDX_W = $clog2(2 * NUM_RANGES + 3);

   logic                          en;
   logic                          range_none;
   dcc_side_type                  in_side;
   dcc_side_type                  sq_side;
   logic                          sq_valid;
   logic [CORDIC_IN_W-1:0]        sq_root;
   logic                          az_valid, pol_valid;
   logic [ANGLE_BITS-1:0]         az_angle, pol_angle;
   logic                          az_final, pol_xy_zero;

   // Incoming side data; a zero xy length fails every azimuth test.
   always_comb begin
      in_side.dir_x       = req_chan.dir_x;
      in_side.dir_y       = req_chan.dir_y;
      in_side.dir_z       = req_chan.dir_z;
      in_side.xy_zero     = (req_chan.dir_x == '0) && (req_chan.dir_y == '0);
      in_side.final_point = req_chan.final_point;
   end

   assign req_chan.ready = en;

   dcc_isqrt_pipe u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_side   (in_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Azimuth from (x, y).
   dcc_cordic_pipe #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_cordic_az (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_x      (CORDIC_IN_W'(sq_side.dir_x)),
      .in_y      (CORDIC_IN_W'(sq_side.dir_y)),
      .in_side   (sq_side.final_point),
      .out_valid (az_valid),
      .out_angle (az_angle),
      .out_side  (az_final)
   );

   // Polar angle from (z, sqrt(1 - z^2)).
   dcc_cordic_pipe #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_cordic_pol (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_x      (CORDIC_IN_W'(sq_side.dir_z)),
      .in_y      ($signed(sq_root)),
      .in_side   (sq_side.xy_zero),
      .out_valid (pol_valid),
      .out_angle (pol_angle),
      .out_side  (pol_xy_zero)
   );

   dcc_range_check #(
      .NUM_RANGES (NUM_RANGES),
      .ANGLE_BITS (ANGLE_BITS),
      .CSR_IDX_W  (CSR_IDX_W)
   ) u_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_valid    (pol_valid),
      .azimuth     (az_angle),
      .polar       (pol_angle),
      .xy_zero     (pol_xy_zero),
      .final_point (az_final),
      .en          (en),
      .range_none  (range_none),
      .rsp         (rsp_chan)
   );

`ifndef SYNTHESIS
   // The two CORDIC pipes must stay in lockstep.
   a_pipes_aligned: assert property (@(posedge clock) disable iff (reset)
      az_valid == pol_valid)
      else $error("CORDIC pipes out of step");

   // With no active range nothing can be inside.
   a_no_range_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && range_none) |-> !rsp_chan.inside_res)
      else $error("inside reported with no active range");

   // A zero xy length entering the check stage never yields a hit.
   a_zero_xy_miss: assert property (@(posedge clock) disable iff (reset)
      (pol_valid && pol_xy_zero && en) |=> !rsp_chan.inside_res)
      else $error("inside reported for zero xy length");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");
`endif

endmodule

@@ hdl/dcc_isqrt_pipe.sv @@
// Pipelined integer square root of 2^30 - z^2, one result bit per stage.
// Depends on dcc_pkg; carries the side data of each item along.
module dcc_isqrt_pipe (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  dcc_pkg::dcc_side_type            in_side,
   output logic                             out_valid,
   output logic [dcc_pkg::CORDIC_IN_W-1:0]  out_root,
   output dcc_pkg::dcc_side_type            out_side
);
   import dcc_pkg::*;

   localparam int NSTG = SQRT_STEPS + 2;

   logic                valid_ff [NSTG];
   logic                valid_in [NSTG];
   dcc_side_type        side_ff  [NSTG];
   dcc_side_type        side_in  [NSTG];
   logic [SQRT_W-1:0]   rem_ff   [NSTG];
   logic [SQRT_W-1:0]   rem_in   [NSTG];
   logic [SQRT_W-1:0]   root_ff  [NSTG];
   logic [SQRT_W-1:0]   root_in  [NSTG];

   // First stage squares z at full width, second forms the radicand.
   always_comb begin
      valid_in[0] = in_valid;
      side_in[0]  = in_side;
      rem_in[0]   = SQRT_W'($signed(SQRT_W'(in_side.dir_z)) *
                            $signed(SQRT_W'(in_side.dir_z)));
      root_in[0]  = '0;
      valid_in[1] = valid_ff[0];
      side_in[1]  = side_ff[0];
      rem_in[1]   = UNIT_SQ - rem_ff[0];
      root_in[1]  = '0;
   end

   // Each later stage settles one result bit.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQRT_W-1:0] trial;
      always_comb begin
         trial          = root_ff[k+1] + BIT;
         valid_in[k+2]  = valid_ff[k+1];
         side_in[k+2]   = side_ff[k+1];
         if (rem_ff[k+1] >= trial) begin
            rem_in[k+2]  = rem_ff[k+1] - trial;
            root_in[k+2] = (root_ff[k+1] >> 1) + BIT;
         end else begin
            rem_in[k+2]  = rem_ff[k+1];
            root_in[k+2] = root_ff[k+1] >> 1;
         end
      end
   end

   // Stage registers; valid bits are cleared by reset.
   for (genvar s = 0; s < NSTG; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_in[s];
         end
         if (en) begin
            side_ff[s] <= side_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NSTG-1];
   assign out_root  = root_ff[NSTG-1][CORDIC_IN_W-1:0];
   assign out_side  = side_ff[NSTG-1];

endmodule

@@ hdl/dcc_cordic_pipe.sv @@
// Vectoring CORDIC pipe: one micro-rotation per stage, angle rounded at the end.
// Depends on dcc_pkg for the arctangent table and operand widths.
module dcc_cordic_pipe #(
   parameter int ANGLE_BITS = 16,
   parameter int SIDE_W     = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [dcc_pkg::CORDIC_IN_W-1:0]  in_x,
   input  logic signed [dcc_pkg::CORDIC_IN_W-1:0]  in_y,
   input  logic [SIDE_W-1:0]                       in_side,
   output logic                                    out_valid,
   output logic [ANGLE_BITS-1:0]                   out_angle,
   output logic [SIDE_W-1:0]                       out_side
);
   import dcc_pkg::*;

   localparam int NSTG = CORDIC_STEPS + 1;
   localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(1) << (ACC_W - 1);
   localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);

   logic                        valid_ff [NSTG];
   logic                        valid_in [NSTG];
   logic [SIDE_W-1:0]           side_ff  [NSTG];
   logic [SIDE_W-1:0]           side_in  [NSTG];
   logic signed [CORDIC_XW-1:0] x_ff     [NSTG];
   logic signed [CORDIC_XW-1:0] x_in     [NSTG];
   logic signed [CORDIC_XW-1:0] y_ff     [NSTG];
   logic signed [CORDIC_XW-1:0] y_in     [NSTG];
   logic [ACC_W-1:0]            acc_ff   [NSTG];
   logic [ACC_W-1:0]            acc_in   [NSTG];
   logic                        res_valid_ff, res_valid_in;
   logic [ANGLE_BITS-1:0]       angle_ff, angle_in;
   logic [SIDE_W-1:0]           res_side_ff, res_side_in;
   logic [ACC_W-1:0]            rounded;

   // Scale the operands and fold the left half plane onto the right.
   always_comb begin
      logic signed [CORDIC_XW-1:0] xs;
      logic signed [CORDIC_XW-1:0] ys;
      xs          = CORDIC_XW'(in_x) <<< CORDIC_SHIFT;
      ys          = CORDIC_XW'(in_y) <<< CORDIC_SHIFT;
      valid_in[0] = in_valid;
      side_in[0]  = in_side;
      if (xs < 0) begin
         x_in[0]   = -xs;
         y_in[0]   = -ys;
         acc_in[0] = HALF_TURN;
      end else begin
         x_in[0]   = xs;
         y_in[0]   = ys;
         acc_in[0] = '0;
      end
   end

   // One micro-rotation per stage, driving y toward zero.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [CORDIC_XW-1:0] dx;
      logic signed [CORDIC_XW-1:0] dy;
      always_comb begin
         dx            = y_ff[i] >>> i;
         dy            = x_ff[i] >>> i;
         valid_in[i+1] = valid_ff[i];
         side_in[i+1]  = side_ff[i];
         if (!y_ff[i][CORDIC_XW-1]) begin
            x_in[i+1]   = x_ff[i] + dx;
            y_in[i+1]   = y_ff[i] - dy;
            acc_in[i+1] = acc_ff[i] + ATAN_TAB[i];
         end else begin
            x_in[i+1]   = x_ff[i] - dx;
            y_in[i+1]   = y_ff[i] + dy;
            acc_in[i+1] = acc_ff[i] - ATAN_TAB[i];
         end
      end
   end

   for (genvar s = 0; s < NSTG; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_in[s];
         end
         if (en) begin
            side_ff[s] <= side_in[s];
            x_ff[s]    <= x_in[s];
            y_ff[s]    <= y_in[s];
            acc_ff[s]  <= acc_in[s];
         end
      end
   end

   // Round half up to the output angle width; the full circle wraps.
   always_comb begin
      rounded      = acc_ff[NSTG-1] + ROUND_ADD;
      angle_in     = rounded[ACC_W-1 -: ANGLE_BITS];
      res_valid_in = valid_ff[NSTG-1];
      res_side_in  = side_ff[NSTG-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (en) begin
         res_valid_ff <= res_valid_in;
      end
      if (en) begin
         angle_ff    <= angle_in;
         res_side_ff <= res_side_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_angle = angle_ff;
   assign out_side  = res_side_ff;

endmodule

@@ hdl/dcc_range_check.sv @@
// Configuration registers, the angle range tests and the response register.
// Depends on dcc_pkg and on the response interface.
module dcc_range_check #(
   parameter int NUM_RANGES = 2,
   parameter int ANGLE_BITS = 16,
   parameter int CSR_IDX_W  = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [ANGLE_BITS-1:0]  csr_wdata,
   input  logic                   in_valid,
   input  logic [ANGLE_BITS-1:0]  azimuth,
   input  logic [ANGLE_BITS-1:0]  polar,
   input  logic                   xy_zero,
   input  logic                   final_point,
   output logic                   en,
   output logic                   range_none,
   dcc_rsp_if.source              rsp
);
   import dcc_pkg::*;

   localparam int CSR_POLAR_LOW  = CSR_RANGE_BASE + 2 * NUM_RANGES;
   localparam int CSR_POLAR_HIGH = CSR_POLAR_LOW + 1;
   localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

   logic [RANGE_COUNT_W-1:0] range_count_ff;
   logic [ANGLE_BITS-1:0]    range_start_ff [NUM_RANGES];
   logic [ANGLE_BITS-1:0]    range_end_ff   [NUM_RANGES];
   logic [ANGLE_BITS-1:0]    polar_low_ff, polar_high_ff;
   logic [NUM_RANGES-1:0]    hit;
   logic                     valid_ff, valid_in;
   logic                     inside_ff, inside_in;
   logic                     final_ff, final_in;
   logic                     polar_ok;

   // Register writes; an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
         polar_low_ff   <= '0;
         polar_high_ff  <= HALF_TURN;
      end else if (csr_we) begin
         if (32'(csr_index) == CSR_RANGE_COUNT) begin
            range_count_ff <= csr_wdata[RANGE_COUNT_W-1:0];
         end
         if (32'(csr_index) == CSR_POLAR_LOW) begin
            polar_low_ff <= csr_wdata;
         end
         if (32'(csr_index) == CSR_POLAR_HIGH) begin
            polar_high_ff <= csr_wdata;
         end
      end
   end

   for (genvar r = 0; r < NUM_RANGES; r++) begin : g_range
      localparam int IDX_START = CSR_RANGE_BASE + 2 * r;
      always_ff @(posedge clock) begin
         if (reset) begin
            range_start_ff[r] <= '0;
            range_end_ff[r]   <= '1;
         end else if (csr_we) begin
            if (32'(csr_index) == IDX_START) begin
               range_start_ff[r] <= csr_wdata;
            end
            if (32'(csr_index) == IDX_START + 1) begin
               range_end_ff[r] <= csr_wdata;
            end
         end
      end

      // A range whose start is past its end wraps through zero.
      always_comb begin
         if (range_start_ff[r] > range_end_ff[r]) begin
            hit[r] = (azimuth >= range_start_ff[r]) || (azimuth <= range_end_ff[r]);
         end else begin
            hit[r] = (azimuth >= range_start_ff[r]) && (azimuth <= range_end_ff[r]);
         end
         if (32'(r) >= 32'(range_count_ff)) begin
            hit[r] = 1'b0;
         end
      end
   end

   // The whole pipe moves whenever the response register can take a value.
   assign en         = !valid_ff || rsp.ready;
   assign range_none = (range_count_ff == '0);

   always_comb begin
      polar_ok  = (polar >= polar_low_ff) && (polar <= polar_high_ff);
      inside_in = polar_ok && !xy_zero && (|hit);
      valid_in  = in_valid;
      final_in  = final_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         inside_ff <= inside_in;
         final_ff  <= final_in;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.inside_res      = inside_ff;
   assign rsp.final_point_out = final_ff;

endmodule
